FILE: rtl/core/tcw_pkg.sv
// Shared types and constants for the text console writer.
package tcw_pkg;

	localparam int COLUMNS_DEF = 80;
	localparam int ROWS_DEF    = 25;

	localparam int CHAR_W    = 8;
	localparam int ATTR_W    = 8;
	localparam int CELL_W    = CHAR_W + ATTR_W;
	localparam int ROW_OUT_W = 5;
	localparam int COL_OUT_W = 7;
	localparam int PADDR_W   = 3;
	localparam int PDATA_W   = 32;

	localparam logic [1:0] KIND_PUT   = 2'd0;
	localparam logic [1:0] KIND_READ  = 2'd1;
	localparam logic [1:0] KIND_CLEAR = 2'd2;

	localparam logic [0:0] REG_ATTR = 1'b0;

	localparam logic [CHAR_W-1:0] CODE_NEWLINE = 8'd10;
	localparam logic [CHAR_W-1:0] CODE_SPACE   = 8'd32;
	localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'd7;

	typedef struct packed {
		logic [1:0]           kind;
		logic [CHAR_W-1:0]    char_code;
		logic [ROW_OUT_W-1:0] read_row;
		logic [COL_OUT_W-1:0] read_col;
	} tcw_req_t;

	typedef struct packed {
		logic [CHAR_W-1:0]    cell_char;
		logic [ATTR_W-1:0]    cell_attr;
		logic [ROW_OUT_W-1:0] cursor_row;
		logic [COL_OUT_W-1:0] cursor_col;
	} tcw_rsp_t;

	typedef struct packed {
		logic load;
		logic exec;
		logic sweep_run;
		logic out_load;
	} tcw_cmd_t;

	typedef struct packed {
		logic sweep_req;
		logic sweep_last;
		logic out_free;
	} tcw_sts_t;

endpackage

FILE: rtl/core/tcw_ctrl.sv
// Controller state machine for the text console writer.
module tcw_ctrl import tcw_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	input  tcw_sts_t sts,
	output tcw_cmd_t cmd
);

	typedef enum logic [4:0] {
		S_INIT  = 5'b00001,
		S_IDLE  = 5'b00010,
		S_EXEC  = 5'b00100,
		S_SWEEP = 5'b01000,
		S_DONE  = 5'b10000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			S_INIT: begin
				cmd.sweep_run = 1'b1;
				if (sts.sweep_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = sts.sweep_req ? S_SWEEP : S_DONE;
			end
			S_SWEEP: begin
				cmd.sweep_run = 1'b1;
				if (sts.sweep_last) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: rtl/core/tcw_dp.sv
// Datapath: cell store, cursor, sweep engine and result register.
module tcw_dp import tcw_pkg::*; #(
	parameter int COLUMNS = COLUMNS_DEF,
	parameter int ROWS    = ROWS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  tcw_req_t          req,
	input  logic [ATTR_W-1:0] attr,
	input  tcw_cmd_t          cmd,
	output tcw_sts_t          sts,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output tcw_rsp_t          rsp
);

	localparam int CELLS  = ROWS * COLUMNS;
	localparam int ROW_W  = $clog2(ROWS);
	localparam int COL_W  = $clog2(COLUMNS);
	localparam int ADDR_W = $clog2(CELLS);
	localparam int COPY_N = (ROWS - 1) * COLUMNS;

	localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(ROWS - 1);
	localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(COLUMNS - 1);
	localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);
	localparam logic [ADDR_W-1:0] COPY_END  = ADDR_W'(COPY_N);
	localparam logic [ADDR_W-1:0] ROW_STEP  = ADDR_W'(COLUMNS);

	logic [CELL_W-1:0] mem [CELLS];

	tcw_req_t          req_q;
	logic [ROW_W-1:0]  line_q;
	logic [COL_W-1:0]  col_q;
	logic [ADDR_W-1:0] sweep_q;
	logic              copy_q;
	logic [CELL_W-1:0] blank_q;
	logic              wv_s1;
	logic [ADDR_W-1:0] waddr_s1;
	logic              wblank_s1;
	logic [CELL_W-1:0] rd_q;
	logic              hit_q;
	tcw_rsp_t          out_q;
	logic              out_valid_q;

	logic              is_put, is_nl, wrap, put_scroll, rd_hit, copy_go;
	logic              put_we, we, rd_en;
	logic [ADDR_W-1:0] cur_addr, rd_cell_addr, copy_addr, rd_addr, waddr;
	logic [CELL_W-1:0] wdata;

	always_comb begin
		is_put     = (req_q.kind == KIND_PUT);
		is_nl      = (req_q.char_code == CODE_NEWLINE);
		wrap       = is_nl || (col_q == LAST_COL);
		put_scroll = is_put && wrap && (line_q == LAST_ROW);

		sts.sweep_req  = put_scroll || (req_q.kind == KIND_CLEAR);
		sts.sweep_last = (sweep_q == LAST_CELL);
		sts.out_free   = !out_valid_q || rsp_ready;

		cur_addr     = ADDR_W'(ADDR_W'(line_q) * ROW_STEP + ADDR_W'(col_q));
		rd_hit       = (int'(req_q.read_row) < ROWS) && (int'(req_q.read_col) < COLUMNS);
		rd_cell_addr = ADDR_W'(ADDR_W'(req_q.read_row) * ROW_STEP + ADDR_W'(req_q.read_col));
		copy_go      = copy_q && (sweep_q < COPY_END);
		copy_addr    = ADDR_W'({1'b0, sweep_q} + (ADDR_W + 1)'(COLUMNS));

		rd_en   = (cmd.exec && (req_q.kind == KIND_READ) && rd_hit) ||
		          (cmd.sweep_run && copy_go);
		rd_addr = cmd.sweep_run ? copy_addr : rd_cell_addr;

		put_we = cmd.exec && is_put && !is_nl;
		we     = put_we || wv_s1;
		waddr  = wv_s1 ? waddr_s1 : cur_addr;
		wdata  = wv_s1 ? (wblank_s1 ? blank_q : rd_q) : {attr, req_q.char_code};
	end

	// single write port, registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req;
		end
		if (cmd.exec) begin
			hit_q <= (req_q.kind == KIND_READ) && rd_hit;
		end
		waddr_s1  <= sweep_q;
		wblank_s1 <= !copy_go;
		if (cmd.out_load) begin
			out_q.cell_char  <= hit_q ? rd_q[CHAR_W-1:0] : '0;
			out_q.cell_attr  <= hit_q ? rd_q[CELL_W-1:CHAR_W] : '0;
			out_q.cursor_row <= ROW_OUT_W'(line_q);
			out_q.cursor_col <= COL_OUT_W'(col_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_q      <= '0;
			col_q       <= '0;
			sweep_q     <= '0;
			copy_q      <= 1'b0;
			blank_q     <= {ATTR_RESET, CODE_SPACE};
			wv_s1       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			wv_s1 <= cmd.sweep_run;
			if (cmd.exec) begin
				if (is_put) begin
					if (wrap) begin
						col_q <= '0;
						if (line_q != LAST_ROW) begin
							line_q <= line_q + 1'b1;
						end
					end else begin
						col_q <= col_q + 1'b1;
					end
				end else if (req_q.kind == KIND_CLEAR) begin
					line_q <= '0;
					col_q  <= '0;
				end
				if (sts.sweep_req) begin
					sweep_q <= '0;
					copy_q  <= is_put;
					blank_q <= {attr, CODE_SPACE};
				end
			end else if (cmd.sweep_run && !sts.sweep_last) begin
				sweep_q <= sweep_q + 1'b1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	a_line_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		line_q <= LAST_ROW)
		else $error("cursor row beyond last row");

	a_col_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		col_q <= LAST_COL)
		else $error("cursor column beyond last column");

	a_no_write_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(put_we && wv_s1))
		else $error("character write collides with sweep write");

	a_sweep_done_once: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.sweep_run && sts.sweep_last) |=> !cmd.sweep_run)
		else $error("sweep runs past the last cell");

endmodule

FILE: rtl/core/text_console_writer.sv
// Text console writer top level: APB register, controller and datapath.
// A request is registered when accepted and executed in S_EXEC; its result is
// registered in S_DONE once the output register is free, and only then does
// the controller return to S_IDLE for the next request. Clear, and a put that
// scrolls, sweep the store one cell per cycle through its single write port.
// After arst_n all ROWS*COLUMNS cells (2000 by default) are blanked, with
// req_ready low; the APB port works throughout.
module text_console_writer import tcw_pkg::*; #(
	parameter int COLUMNS = COLUMNS_DEF,
	parameter int ROWS    = ROWS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  tcw_req_t           req,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output tcw_rsp_t           rsp,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	logic [ATTR_W-1:0] attr_q;
	logic              reg_sel;
	tcw_cmd_t          cmd;
	tcw_sts_t          sts;

	assign pready  = 1'b1;
	assign reg_sel = (paddr[PADDR_W-1:2] == REG_ATTR);
	assign prdata  = reg_sel ? PDATA_W'(attr_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= ATTR_RESET;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			attr_q <= pwdata[ATTR_W-1:0];
		end
	end

	tcw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	tcw_dp #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.attr      (attr_q),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule
